[hw/rtl/vkga_pkg.sv]
// ----------------------------------------------------------------------------
// vkga_pkg
// Types and constants shared by the voxel key group assignment block: request
// and response payloads and the query record that travels along the cells.
// ----------------------------------------------------------------------------
`default_nettype none

package vkga_pkg;

	localparam int COORD_W            = 16;
	localparam int KEY_W              = 3 * COORD_W;
	localparam int GROUP_ID_W         = 10;
	localparam int COUNT_W            = 16;
	localparam int GROUP_CAPACITY_DEF = 1024;

	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
	localparam logic [COUNT_W-1:0] COUNT_ONE = COUNT_W'(1);

	typedef struct packed {
		logic               start_new;
		logic [COORD_W-1:0] cell_x;
		logic [COORD_W-1:0] cell_y;
		logic [COORD_W-1:0] cell_z;
	} vkga_req_t;

	typedef struct packed {
		logic [GROUP_ID_W-1:0] group_id;
		logic                  is_new;
		logic                  table_full;
		logic [COUNT_W-1:0]    member_count;
	} vkga_rsp_t;

	// One request in flight along the chain of cells
	typedef struct packed {
		logic                  valid;
		logic                  start_new;
		logic [KEY_W-1:0]      key;
		logic                  hit;
		logic [GROUP_ID_W-1:0] group_id;
		logic                  is_new;
		logic [COUNT_W-1:0]    member_count;
	} vkga_query_t;

endpackage

`default_nettype wire

[hw/rtl/vkga_cell.sv]
// ----------------------------------------------------------------------------
// vkga_cell
// One group slot of the chain: holds a key, its member count and an in-use
// flag. A passing request clears the slot on a start flag, counts a match,
// or claims the slot if it is the first free one, then moves on a stage.
// ----------------------------------------------------------------------------
`default_nettype none

module vkga_cell
	import vkga_pkg::*;
#(
	parameter int CELL_INDEX = 0
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        advance,
	input  wire vkga_query_t query_in,
	output vkga_query_t      query_out
);

	localparam logic [GROUP_ID_W-1:0] CELL_ID = GROUP_ID_W'(CELL_INDEX);

	logic [KEY_W-1:0]   key_q;
	logic [COUNT_W-1:0] count_q;
	logic               used_q;
	vkga_query_t        query_s1;

	logic               used_eff;
	logic               match;
	logic               fill;
	logic [COUNT_W-1:0] count_inc;
	vkga_query_t        query_d;

	always_comb begin
		used_eff  = used_q && !query_in.start_new;
		match     = query_in.valid && !query_in.hit && used_eff && (query_in.key == key_q);
		fill      = query_in.valid && !query_in.hit && !used_eff;
		count_inc = (count_q == COUNT_MAX) ? count_q : count_q + COUNT_ONE;
		query_d   = query_in;
		if (match) begin
			query_d.hit          = 1'b1;
			query_d.group_id     = CELL_ID;
			query_d.is_new       = 1'b0;
			query_d.member_count = count_inc;
		end else if (fill) begin
			query_d.hit          = 1'b1;
			query_d.group_id     = CELL_ID;
			query_d.is_new       = 1'b1;
			query_d.member_count = COUNT_ONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q   <= 1'b0;
			query_s1 <= '0;
		end else if (advance) begin
			query_s1 <= query_d;
			if (query_in.valid) begin
				used_q <= used_eff || fill;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			if (match) begin
				count_q <= count_inc;
			end else if (fill) begin
				key_q   <= query_in.key;
				count_q <= COUNT_ONE;
			end
		end
	end

	assign query_out = query_s1;

endmodule

`default_nettype wire

[hw/rtl/voxel_key_group_assign.sv]
// ----------------------------------------------------------------------------
// voxel_key_group_assign
// Assigns points to voxel groups in order of first appearance. The packed
// 48-bit key walks a chain of GROUP_CAPACITY cells, one slot per cell.
//
//   channel | signals                       | payload
//   --------+-------------------------------+-----------
//   request | req_valid, req_ready, req_data | vkga_req_t
//   result  | rsp_valid, rsp_ready, rsp_data | vkga_rsp_t
//
// The key walks the cells one per cycle while the chain advances, and the result is registered.
// A new request is taken every cycle while results are taken.
// Requests meet each cell in arrival order, so later ones see earlier inserts.
// Reset empties all slots at once; no clearing pass is needed.
// A stalled result halts the whole chain and holds req_ready low.
// ----------------------------------------------------------------------------
`default_nettype none

module voxel_key_group_assign
	import vkga_pkg::*;
#(
	parameter int GROUP_CAPACITY = GROUP_CAPACITY_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      req_valid,
	output logic           req_ready,
	input  wire vkga_req_t req_data,
	output logic           rsp_valid,
	input  wire logic      rsp_ready,
	output vkga_rsp_t      rsp_data
);

	logic        advance;
	vkga_query_t chain [GROUP_CAPACITY+1];
	logic        rsp_valid_q;
	vkga_rsp_t   rsp_q;

	assign advance   = !rsp_valid_q || rsp_ready;
	assign req_ready = advance;

	always_comb begin
		chain[0].valid        = req_valid;
		chain[0].start_new    = req_data.start_new;
		chain[0].key          = {req_data.cell_z, req_data.cell_y, req_data.cell_x};
		chain[0].hit          = 1'b0;
		chain[0].group_id     = '0;
		chain[0].is_new       = 1'b0;
		chain[0].member_count = '0;
	end

	for (genvar g = 0; g < GROUP_CAPACITY; g++) begin : g_cell
		vkga_cell #(
			.CELL_INDEX(g)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.advance  (advance),
			.query_in (chain[g]),
			.query_out(chain[g+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= chain[GROUP_CAPACITY].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q.group_id     <= chain[GROUP_CAPACITY].group_id;
			rsp_q.is_new       <= chain[GROUP_CAPACITY].is_new;
			rsp_q.table_full   <= !chain[GROUP_CAPACITY].hit;
			rsp_q.member_count <= chain[GROUP_CAPACITY].member_count;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

`ifndef SYNTHESIS
	a_full_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_q.table_full) |->
			(rsp_q.group_id == '0 && rsp_q.member_count == '0 && !rsp_q.is_new))
		else $error("table_full response carries a group");

	a_new_count: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_q.is_new) |-> (rsp_q.member_count == COUNT_ONE))
		else $error("new group with count other than one");

	a_hit_count: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && !rsp_q.table_full) |-> (rsp_q.member_count != '0))
		else $error("assigned group with zero count");

	a_new_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> !(rsp_q.is_new && rsp_q.table_full))
		else $error("response both new and full");
`endif

endmodule

`default_nettype wire

[dv/voxel_key_group_assign_chk.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voxel_key_group_assign_chk
// Watches the request and result channels of the voxel group assigner. Every
// accepted request runs through a group table kept here, and its predicted
// result is queued. Each accepted result is compared field by field with the
// oldest queued prediction. Failures and the queue depth go to the top.
// ----------------------------------------------------------------------------

module voxel_key_group_assign_chk
	import vkga_pkg::*;
#(
	parameter int GROUPS = GROUP_CAPACITY_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	input  logic      req_ready,
	input  vkga_req_t req_data,
	input  logic      rsp_valid,
	input  logic      rsp_ready,
	input  vkga_rsp_t rsp_data,
	output int        errors,
	output int        pending
);

	logic [KEY_W-1:0]   slot_key [GROUPS];
	logic [COUNT_W-1:0] slot_count [GROUPS];
	int unsigned        slots_used = 0;
	vkga_rsp_t          group_rsp_q [$];
	int                 fail_count = 0;

	function automatic vkga_rsp_t assign_group(input vkga_req_t pt);
		logic [KEY_W-1:0] key;
		vkga_rsp_t        res;
		key = {pt.cell_z, pt.cell_y, pt.cell_x};
		res = '0;
		if (pt.start_new) begin
			slots_used = 0;
		end
		for (int i = 0; i < slots_used; i++) begin
			if (slot_key[i] == key) begin
				if (slot_count[i] != COUNT_MAX) begin
					slot_count[i] = slot_count[i] + COUNT_ONE;
				end
				res.group_id     = GROUP_ID_W'(i);
				res.member_count = slot_count[i];
				return res;
			end
		end
		if (slots_used >= GROUPS) begin
			res.table_full = 1'b1;
			return res;
		end
		slot_key[slots_used]   = key;
		slot_count[slots_used] = COUNT_ONE;
		res.group_id           = GROUP_ID_W'(slots_used);
		res.is_new             = 1'b1;
		res.member_count       = COUNT_ONE;
		slots_used++;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		vkga_rsp_t want;
		if (!arst_n) begin
			slots_used = 0;
			group_rsp_q.delete();
			fail_count = 0;
			errors  <= 0;
			pending <= 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (group_rsp_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10) begin
						$display("[%0t] unexpected result: id=%0d new=%0b full=%0b count=%0d",
							$time, rsp_data.group_id, rsp_data.is_new,
							rsp_data.table_full, rsp_data.member_count);
					end
				end else begin
					want = group_rsp_q.pop_front();
					if (rsp_data.group_id !== want.group_id ||
							rsp_data.is_new !== want.is_new ||
							rsp_data.table_full !== want.table_full ||
							rsp_data.member_count !== want.member_count) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("[%0t] mismatch: expected id=%0d new=%0b full=%0b count=%0d",
								$time, want.group_id, want.is_new, want.table_full,
								want.member_count);
							$display("[%0t]           got      id=%0d new=%0b full=%0b count=%0d",
								$time, rsp_data.group_id, rsp_data.is_new,
								rsp_data.table_full, rsp_data.member_count);
						end
					end
				end
			end
			if (req_valid && req_ready) begin
				group_rsp_q = {group_rsp_q, assign_group(req_data)};
			end
			errors  <= fail_count;
			pending <= group_rsp_q.size();
		end
	end

endmodule

[dv/voxel_key_group_assign_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voxel_key_group_assign_tb
// Drives point requests into the voxel group assigner: a directed set of
// edge keys, a full table with overflow, then random point clouds with
// repeated and near-duplicate keys under varied idling and one long result
// hold-off. The checker beside the block predicts results.
// ----------------------------------------------------------------------------

module voxel_key_group_assign_tb;
	import vkga_pkg::*;

	localparam int GROUPS      = GROUP_CAPACITY_DEF;
	localparam int HOLD_CYCLES = 3000;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_ready;
	vkga_req_t req_data  = '0;
	logic      rsp_valid;
	logic      rsp_ready = 1'b0;
	vkga_rsp_t rsp_data;
	int        errors;
	int        pending;

	int        send_idle  = 0;
	int        recv_stall = 0;
	logic      hold_go    = 1'b0;
	logic      hold_seen  = 1'b0;
	int        hold_left  = 0;

	voxel_key_group_assign #(.GROUP_CAPACITY(GROUPS)) dut (.*);

	voxel_key_group_assign_chk #(.GROUPS(GROUPS)) chk (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (hold_go != hold_seen) begin
			hold_seen <= hold_go;
			hold_left <= HOLD_CYCLES;
			rsp_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= ($urandom_range(99) >= recv_stall);
		end
	end

	function automatic logic [KEY_W-1:0] random_key();
		return KEY_W'({$urandom(), $urandom()});
	endfunction

	task automatic send_point(input logic start, input logic [KEY_W-1:0] key);
		vkga_req_t pt;
		pt.start_new = start;
		pt.cell_x    = key[COORD_W-1:0];
		pt.cell_y    = key[2*COORD_W-1:COORD_W];
		pt.cell_z    = key[KEY_W-1:2*COORD_W];
		while ($urandom_range(99) < send_idle) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req_data  <= pt;
		@(posedge clk);
		while (!req_ready) begin
			@(posedge clk);
		end
	endtask

	task automatic send_clouds(input int n_points);
		logic [KEY_W-1:0] pool [48];
		logic [KEY_W-1:0] key;
		int               pool_n;
		int               cloud_len;
		int               left;
		left = n_points;
		while (left > 0) begin
			pool_n = $urandom_range(1, 48);
			for (int k = 0; k < pool_n; k++) begin
				if (k > 0 && $urandom_range(3) == 0) begin
					pool[k] = pool[k-1] ^ (KEY_W'(1) << $urandom_range(KEY_W - 1));
				end else begin
					pool[k] = random_key();
				end
			end
			cloud_len = $urandom_range(1, 120);
			if (cloud_len > left) begin
				cloud_len = left;
			end
			for (int j = 0; j < cloud_len; j++) begin
				if ($urandom_range(99) < 10) begin
					key = random_key();
				end else begin
					key = pool[$urandom_range(pool_n - 1)];
				end
				send_point(j == 0 || $urandom_range(99) < 2, key);
			end
			left -= cloud_len;
		end
	endtask

	task automatic fill_table();
		logic [KEY_W-1:0] filled [GROUPS];
		logic [KEY_W-1:0] key;
		for (int i = 0; i < GROUPS; i++) begin
			key       = random_key();
			filled[i] = {key[KEY_W-1:COORD_W], COORD_W'(i)};
			send_point(i == 0, filled[i]);
		end
		for (int i = 0; i < 60; i++) begin
			if ($urandom_range(1) == 0) begin
				key = random_key();
				send_point(1'b0, {key[KEY_W-1:COORD_W],
					COORD_W'($urandom_range(GROUPS, 65535))});
			end else begin
				send_point(1'b0, filled[$urandom_range(GROUPS - 1)]);
			end
		end
		send_point(1'b1, filled[GROUPS-1]);
		send_point(1'b0, filled[0]);
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_point(1'b1, '0);
		send_point(1'b0, '0);
		send_point(1'b0, '1);
		send_point(1'b0, {16'h0000, 16'h0000, 16'hFFFF});
		send_point(1'b0, {16'h0000, 16'hFFFF, 16'h0000});
		send_point(1'b0, {16'hFFFF, 16'h0000, 16'h0000});
		send_point(1'b0, {16'h0000, 16'h0000, 16'h0001});
		send_point(1'b0, {16'h0000, 16'h0001, 16'h0000});
		send_point(1'b0, {16'h0001, 16'h0000, 16'h0000});
		send_point(1'b0, {16'hAAAA, 16'h5555, 16'hAAAA});
		send_point(1'b0, {16'h5555, 16'hAAAA, 16'h5555});
		send_point(1'b0, '1);
		send_point(1'b0, {16'h0000, 16'h0000, 16'hFFFF});
		send_point(1'b1, '1);
		send_point(1'b1, '1);
		send_point(1'b0, '0);
		send_point(1'b0, '1);

		send_idle = 45;
		fill_table();
		send_clouds(220);

		send_idle = 0;
		recv_stall <= 45;
		hold_go    <= ~hold_go;
		send_clouds(220);

		send_idle = 8;
		recv_stall <= 8;
		send_clouds(210);

		req_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) begin
			@(posedge clk);
		end
		repeat (GROUPS + 16) @(posedge clk);
		if (errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule

[sim.f]
hw/rtl/vkga_pkg.sv
hw/rtl/vkga_cell.sv
hw/rtl/voxel_key_group_assign.sv
dv/voxel_key_group_assign_chk.sv
dv/voxel_key_group_assign_tb.sv
